FILE: src/cbc_pkg.sv
// cbc_pkg: shared types for the circle/box collide-and-resolve block.
// No dependencies; used by circle_box_collide_resolve_unit.
package cbc_pkg;

   // Push direction codes reported with each result.
   typedef enum logic [1:0] {
      PUSH_RIGHT = 2'd0,
      PUSH_LEFT  = 2'd1,
      PUSH_UP    = 2'd2,
      PUSH_DOWN  = 2'd3
   } push_dir_type;

endpackage

FILE: src/cbc_sqrt_pipe.sv
// cbc_sqrt_pipe: pipelined floor square root, one root bit per register stage.
// Carries an opaque tag alongside each operand. No package dependencies.
module cbc_sqrt_pipe #(
   parameter int ROOT_WIDTH = 24,
   parameter int TAG_WIDTH  = 74
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [2*ROOT_WIDTH-1:0]   in_radicand,
   input  logic [TAG_WIDTH-1:0]      in_tag,
   output logic                      out_valid,
   output logic [ROOT_WIDTH-1:0]     out_root,
   output logic [TAG_WIDTH-1:0]      out_tag
);

   localparam int RemWidth   = 2 * ROOT_WIDTH;
   localparam int TrialWidth = 2 * ROOT_WIDTH + 1;

   logic                  valid_ff [ROOT_WIDTH];
   logic [RemWidth-1:0]   rem_ff   [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff  [ROOT_WIDTH];
   logic [TAG_WIDTH-1:0]  tag_ff   [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
      localparam int BitPos = ROOT_WIDTH - 1 - k;

      logic                  valid_prev;
      logic [RemWidth-1:0]   rem_prev;
      logic [ROOT_WIDTH-1:0] root_prev;
      logic [TAG_WIDTH-1:0]  tag_prev;
      logic [TrialWidth-1:0] trial;
      logic                  take;
      logic [RemWidth-1:0]   rem_in;
      logic [ROOT_WIDTH-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_radicand;
         assign root_prev  = '0;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
      assign trial   = (TrialWidth'(root_prev) << (BitPos + 1))
                     + (TrialWidth'(1) << (2 * BitPos));
      assign take    = TrialWidth'(rem_prev) >= trial;
      assign rem_in  = take ? rem_prev - trial[RemWidth-1:0] : rem_prev;
      assign root_in = take ? root_prev | (ROOT_WIDTH'(1) << BitPos) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         tag_ff[k]  <= tag_prev;
      end
   end

   assign out_valid = valid_ff[ROOT_WIDTH-1];
   assign out_root  = root_ff[ROOT_WIDTH-1];
   assign out_tag   = tag_ff[ROOT_WIDTH-1];

endmodule

FILE: src/circle_box_collide_resolve_unit.sv
// circle_box_collide_resolve_unit: circle versus axis-aligned box collision with push-out.
// Depends on cbc_pkg (push direction codes) and cbc_sqrt_pipe (pipelined square root).

// Fully pipelined: a transaction may be started on every clock cycle and busy is
// always low. Each transaction yields exactly one result, strobed on rsp_valid for
// one cycle; results come out in start order. The latency is set by the square-root
// pipeline, which resolves one root bit per stage (COORD_WIDTH stages), plus five
// stages in front (centre and extents, clamp and offset, magnitude/direction,
// squares, sum) and two behind (hit test, push and saturation). The receiver must
// take every result.
module circle_box_collide_resolve_unit #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_circle_x,
   input  logic signed [COORD_WIDTH-1:0] req_circle_y,
   input  logic [COORD_WIDTH-2:0]        req_circle_radius,
   input  logic                          req_circle_active,
   input  logic signed [COORD_WIDTH-1:0] req_box_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_y,
   input  logic [COORD_WIDTH-2:0]        req_box_width,
   input  logic [COORD_WIDTH-2:0]        req_box_height,
   input  logic                          req_box_active,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [1:0]                    rsp_push_direction,
   output logic signed [COORD_WIDTH-1:0] rsp_new_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_y
);

   localparam int W        = COORD_WIDTH;
   localparam int Ext1     = W + 1;
   localparam int Ext2     = W + 2;
   localparam int SqWidth  = 2 * W - 2;
   localparam int SumWidth = 2 * W - 1;
   localparam int TagWidth = 3 * W + 2;
   localparam int Latency  = W + 7;

   // The pipeline never stalls.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Stage 1: circle centre and box extents.
   logic                   s1_valid_ff;
   logic                   s1_act_ff;
   logic signed [W:0]      s1_mx_ff, s1_my_ff;
   logic signed [W:0]      s1_bxlo_ff, s1_bxhi_ff, s1_bylo_ff, s1_byhi_ff;
   logic [W-2:0]           s1_r_ff;
   logic signed [W-1:0]    s1_cx_ff, s1_cy_ff;

   logic signed [W:0]      s1_mx_in, s1_my_in, s1_bxhi_in, s1_byhi_in;

   assign s1_mx_in   = Ext1'(req_circle_x) + Ext1'($signed({1'b0, req_circle_radius}));
   assign s1_my_in   = Ext1'(req_circle_y) + Ext1'($signed({1'b0, req_circle_radius}));
   assign s1_bxhi_in = Ext1'(req_box_x) + Ext1'($signed({1'b0, req_box_width}));
   assign s1_byhi_in = Ext1'(req_box_y) + Ext1'($signed({1'b0, req_box_height}));

   always_ff @(posedge clock) begin
      s1_act_ff  <= req_circle_active && req_box_active;
      s1_mx_ff   <= s1_mx_in;
      s1_my_ff   <= s1_my_in;
      s1_bxlo_ff <= Ext1'(req_box_x);
      s1_bxhi_ff <= s1_bxhi_in;
      s1_bylo_ff <= Ext1'(req_box_y);
      s1_byhi_ff <= s1_byhi_in;
      s1_r_ff    <= req_circle_radius;
      s1_cx_ff   <= req_circle_x;
      s1_cy_ff   <= req_circle_y;
   end

   // Stage 2: clamp the centre to the box and form the offset vector.
   logic                   s2_valid_ff;
   logic                   s2_act_ff;
   logic signed [W+1:0]    s2_ox_ff, s2_oy_ff;
   logic [W-2:0]           s2_r_ff;
   logic signed [W-1:0]    s2_cx_ff, s2_cy_ff;

   logic signed [W:0]      s2_clx, s2_cly;
   logic signed [W+1:0]    s2_ox_in, s2_oy_in;

   always_comb begin
      priority if (s1_mx_ff < s1_bxlo_ff) begin
         s2_clx = s1_bxlo_ff;
      end else if (s1_mx_ff > s1_bxhi_ff) begin
         s2_clx = s1_bxhi_ff;
      end else begin
         s2_clx = s1_mx_ff;
      end
      priority if (s1_my_ff < s1_bylo_ff) begin
         s2_cly = s1_bylo_ff;
      end else if (s1_my_ff > s1_byhi_ff) begin
         s2_cly = s1_byhi_ff;
      end else begin
         s2_cly = s1_my_ff;
      end
   end

   assign s2_ox_in = Ext2'(s2_clx) - Ext2'(s1_mx_ff);
   assign s2_oy_in = Ext2'(s2_cly) - Ext2'(s1_my_ff);

   always_ff @(posedge clock) begin
      s2_act_ff <= s1_act_ff;
      s2_ox_ff  <= s2_ox_in;
      s2_oy_ff  <= s2_oy_in;
      s2_r_ff   <= s1_r_ff;
      s2_cx_ff  <= s1_cx_ff;
      s2_cy_ff  <= s1_cy_ff;
   end

   // Stage 3: magnitudes, near test and push direction.
   logic                   s3_valid_ff;
   logic                   s3_near_ff;
   cbc_pkg::push_dir_type  s3_dir_ff;
   logic [W-2:0]           s3_ax_ff, s3_ay_ff;
   logic [W-2:0]           s3_r_ff;
   logic signed [W-1:0]    s3_cx_ff, s3_cy_ff;

   logic [W+1:0]           s3_axm, s3_aym;
   logic                   s3_near_in;
   cbc_pkg::push_dir_type  s3_dir_in;

   assign s3_axm = s2_ox_ff[W+1] ? $unsigned(-s2_ox_ff) : $unsigned(s2_ox_ff);
   assign s3_aym = s2_oy_ff[W+1] ? $unsigned(-s2_oy_ff) : $unsigned(s2_oy_ff);
   // Beyond the radius on either axis there is no hit; the root is then unused.
   assign s3_near_in = s2_act_ff && (s3_axm < Ext2'(s2_r_ff)) && (s3_aym < Ext2'(s2_r_ff));

   // Larger axis wins, horizontal on a tie; zero offset pushes right.
   always_comb begin
      priority if (s3_aym > s3_axm) begin
         s3_dir_in = s2_oy_ff[W+1] ? cbc_pkg::PUSH_DOWN : cbc_pkg::PUSH_UP;
      end else if (!s2_ox_ff[W+1] && (s2_ox_ff != '0)) begin
         s3_dir_in = cbc_pkg::PUSH_LEFT;
      end else begin
         s3_dir_in = cbc_pkg::PUSH_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      s3_near_ff <= s3_near_in;
      s3_dir_ff  <= s3_dir_in;
      s3_ax_ff   <= s3_axm[W-2:0];
      s3_ay_ff   <= s3_aym[W-2:0];
      s3_r_ff    <= s2_r_ff;
      s3_cx_ff   <= s2_cx_ff;
      s3_cy_ff   <= s2_cy_ff;
   end

   // Stage 4: squares.
   logic                   s4_valid_ff;
   logic [SqWidth-1:0]     s4_sqx_ff, s4_sqy_ff;
   logic [TagWidth-1:0]    s4_tag_ff;

   always_ff @(posedge clock) begin
      s4_sqx_ff <= SqWidth'(s3_ax_ff) * SqWidth'(s3_ax_ff);
      s4_sqy_ff <= SqWidth'(s3_ay_ff) * SqWidth'(s3_ay_ff);
      s4_tag_ff <= {s3_near_ff, s3_dir_ff, s3_r_ff, s3_cx_ff, s3_cy_ff};
   end

   // Stage 5: squared distance.
   logic                   s5_valid_ff;
   logic [SumWidth-1:0]    s5_sum_ff;
   logic [TagWidth-1:0]    s5_tag_ff;

   always_ff @(posedge clock) begin
      s5_sum_ff <= SumWidth'(s4_sqx_ff) + SumWidth'(s4_sqy_ff);
      s5_tag_ff <= s4_tag_ff;
   end

   // Valid bits for the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Square root, one bit per stage.
   logic                   sq_valid;
   logic [W-1:0]           sq_root;
   logic [TagWidth-1:0]    sq_tag;

   cbc_sqrt_pipe #(
      .ROOT_WIDTH (W),
      .TAG_WIDTH  (TagWidth)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s5_valid_ff),
      .in_radicand ({1'b0, s5_sum_ff}),
      .in_tag      (s5_tag_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_tag     (sq_tag)
   );

   logic                   sq_near;
   logic [1:0]             sq_dir;
   logic [W-2:0]           sq_r;
   logic signed [W-1:0]    sq_cx, sq_cy;

   assign {sq_near, sq_dir, sq_r, sq_cx, sq_cy} = sq_tag;

   // Final stage 1: hit test and push distance.
   logic                   f1_valid_ff;
   logic                   f1_hit_ff;
   cbc_pkg::push_dir_type  f1_dir_ff;
   logic [W-2:0]           f1_diff_ff;
   logic signed [W-1:0]    f1_cx_ff, f1_cy_ff;

   logic                   f1_hit_in;
   logic [W-1:0]           f1_diff_full;

   assign f1_hit_in    = sq_near && (sq_root < {1'b0, sq_r});
   assign f1_diff_full = {1'b0, sq_r} - sq_root;

   always_ff @(posedge clock) begin
      f1_hit_ff  <= f1_hit_in;
      f1_dir_ff  <= f1_hit_in ? cbc_pkg::push_dir_type'(sq_dir) : cbc_pkg::PUSH_RIGHT;
      f1_diff_ff <= f1_diff_full[W-2:0];
      f1_cx_ff   <= sq_cx;
      f1_cy_ff   <= sq_cy;
   end

   // Final stage 2: apply the push and saturate.
   logic                   f2_valid_ff;
   logic                   f2_hit_ff;
   cbc_pkg::push_dir_type  f2_dir_ff;
   logic signed [W-1:0]    f2_x_ff, f2_y_ff;

   logic signed [W:0]      f2_px, f2_py;
   logic signed [W:0]      f2_diff_ext;
   logic signed [W-1:0]    f2_x_in, f2_y_in;

   function automatic logic signed [W-1:0] sat_coord(input logic signed [W:0] v);
      logic signed [W-1:0] res;
      if (v[W] != v[W-1]) begin
         res = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         res = v[W-1:0];
      end
      return res;
   endfunction

   assign f2_diff_ext = $signed({2'b00, f1_diff_ff});

   always_comb begin
      f2_px = Ext1'(f1_cx_ff);
      f2_py = Ext1'(f1_cy_ff);
      if (f1_hit_ff) begin
         unique case (f1_dir_ff)
            cbc_pkg::PUSH_RIGHT: f2_px = Ext1'(f1_cx_ff) + f2_diff_ext;
            cbc_pkg::PUSH_LEFT:  f2_px = Ext1'(f1_cx_ff) - f2_diff_ext;
            cbc_pkg::PUSH_UP:    f2_py = Ext1'(f1_cy_ff) - f2_diff_ext;
            cbc_pkg::PUSH_DOWN:  f2_py = Ext1'(f1_cy_ff) + f2_diff_ext;
         endcase
      end
   end

   assign f2_x_in = sat_coord(f2_px);
   assign f2_y_in = sat_coord(f2_py);

   always_ff @(posedge clock) begin
      f2_hit_ff <= f1_hit_ff;
      f2_dir_ff <= f1_dir_ff;
      f2_x_ff   <= f2_x_in;
      f2_y_ff   <= f2_y_in;
   end

   // Valid bits for the back stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= sq_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   // Result strobe and payload.
   assign rsp_valid          = f2_valid_ff;
   assign rsp_hit            = f2_hit_ff;
   assign rsp_push_direction = f2_dir_ff;
   assign rsp_new_x          = f2_x_ff;
   assign rsp_new_y          = f2_y_ff;

`ifndef ASSERT_OFF
   // Every result traces back to a transaction started a fixed latency earlier.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, Latency))
      else $error("result without a matching start");

   // No hit reports the default direction.
   a_miss_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_push_direction == cbc_pkg::PUSH_RIGHT))
      else $error("miss with nonzero push direction");

   // A horizontal push leaves the vertical position as it came in.
   a_horiz_keeps_y: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_push_direction == cbc_pkg::PUSH_RIGHT)
                  || (rsp_push_direction == cbc_pkg::PUSH_LEFT)))
      |-> (rsp_new_y == $past(req_circle_y, Latency)))
      else $error("horizontal push changed y");
`endif

endmodule

FILE: dv/tb_circle_box_collide_resolve_unit.sv
// Self-checking testbench for circle_box_collide_resolve_unit: circle/box overlap and push-out.
// Depends on cbc_pkg (push direction codes) and the unit itself, which also needs cbc_sqrt_pipe.
// Drives shape pairs in bursts, predicts each result, and checks results in start order.
module tb_circle_box_collide_resolve_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CW          = 24;
   localparam longint POS_MAX     = (longint'(1) << (CW - 1)) - 1;
   localparam longint POS_MIN     = -(longint'(1) << (CW - 1));
   localparam longint SIZE_MAX    = (longint'(1) << (CW - 1)) - 1;
   localparam int     RANDOM_ITEMS = 1700;
   // Margin past the unit's pipeline depth so the tail can drain.
   localparam int     TAIL_CYCLES = CW + 16;
   localparam int     STALL_LIMIT = 2000;

   // One circle/box pair as presented on the request ports.
   typedef struct {
      logic signed [CW-1:0] circle_x;
      logic signed [CW-1:0] circle_y;
      logic [CW-2:0]        circle_radius;
      logic                 circle_active;
      logic signed [CW-1:0] box_x;
      logic signed [CW-1:0] box_y;
      logic [CW-2:0]        box_width;
      logic [CW-2:0]        box_height;
      logic                 box_active;
      bit                   drain_first;   // hold this pair until nothing is in flight
   } shape_pair_type;

   typedef struct {
      logic                   hit;
      cbc_pkg::push_dir_type  dir;
      logic signed [CW-1:0]   new_x;
      logic signed [CW-1:0]   new_y;
   } push_result_type;

   // Clock and reset; every DUT input starts at a known value.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [CW-1:0] req_circle_x = '0;
   logic signed [CW-1:0] req_circle_y = '0;
   logic [CW-2:0]        req_circle_radius = '0;
   logic                 req_circle_active = 1'b0;
   logic signed [CW-1:0] req_box_x = '0;
   logic signed [CW-1:0] req_box_y = '0;
   logic [CW-2:0]        req_box_width = '0;
   logic [CW-2:0]        req_box_height = '0;
   logic                 req_box_active = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_hit;
   logic [1:0]           rsp_push_direction;
   logic signed [CW-1:0] rsp_new_x;
   logic signed [CW-1:0] rsp_new_y;

   shape_pair_type  pair_q[$];       // pairs waiting to be sent
   push_result_type push_q[$];       // predicted push results, oldest first
   push_result_type push_exp;

   int sent_cnt     = 0;
   int rsp_cnt      = 0;
   int err_cnt      = 0;
   int miss_cnt     = 0;
   int dir_hits[4]  = '{0, 0, 0, 0};
   int burst_left   = 1;
   int gap_left     = 0;
   int stall_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   circle_box_collide_resolve_unit #(
      .COORD_WIDTH(CW)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_circle_x       (req_circle_x),
      .req_circle_y       (req_circle_y),
      .req_circle_radius  (req_circle_radius),
      .req_circle_active  (req_circle_active),
      .req_box_x          (req_box_x),
      .req_box_y          (req_box_y),
      .req_box_width      (req_box_width),
      .req_box_height     (req_box_height),
      .req_box_active     (req_box_active),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_push_direction (rsp_push_direction),
      .rsp_new_x          (rsp_new_x),
      .rsp_new_y          (rsp_new_y)
   );

   //--------------------------------------------------------------------------
   // Prediction
   //--------------------------------------------------------------------------

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Floor of the square root, one result bit per pass.
   function automatic longint unsigned floor_root(longint unsigned s);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = longint'(1) << 62;
      while (probe > s) probe = probe >> 2;
      while (probe != 0) begin
         if (s >= root + probe) begin
            s    = s - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Closest box point by clamping the circle centre, then push away along the
   // axis of the most negative candidate; horizontal wins ties.
   function automatic push_result_type resolve_collision(shape_pair_type p);
      push_result_type res;
      longint          cx, cy, rad, bx, by, bw, bh;
      longint          mx, my, ox, oy, ax, ay, root_len, diff, nx, ny, best;
      longint          cand[4];
      int              pick;
      cx   = p.circle_x;
      cy   = p.circle_y;
      rad  = p.circle_radius;
      bx   = p.box_x;
      by   = p.box_y;
      bw   = p.box_width;
      bh   = p.box_height;
      nx   = cx;
      ny   = cy;
      pick = 0;
      res.hit = 1'b0;
      res.dir = cbc_pkg::PUSH_RIGHT;
      if (p.circle_active && p.box_active) begin
         mx = cx + rad;
         my = cy + rad;
         ox = clamp_range(mx, bx, bx + bw) - mx;
         oy = clamp_range(my, by, by + bh) - my;
         ax = (ox < 0) ? -ox : ox;
         ay = (oy < 0) ? -oy : oy;
         // Skip the root when one axis alone is already out of reach.
         if (ax < rad && ay < rad) begin
            root_len = longint'(floor_root(longint'(ax * ax + ay * ay)));
            if (root_len < rad) begin
               diff    = rad - root_len;
               cand[0] = ox;
               cand[1] = -ox;
               cand[2] = -oy;
               cand[3] = oy;
               best    = 0;
               for (int i = 0; i < 4; i++) begin
                  if (cand[i] < best) begin
                     best = cand[i];
                     pick = i;
                  end
               end
               res.hit = 1'b1;
               res.dir = cbc_pkg::push_dir_type'(pick);
               case (res.dir)
                  cbc_pkg::PUSH_RIGHT: nx = cx + diff;
                  cbc_pkg::PUSH_LEFT:  nx = cx - diff;
                  cbc_pkg::PUSH_UP:    ny = cy - diff;
                  cbc_pkg::PUSH_DOWN:  ny = cy + diff;
               endcase
               nx = clamp_range(nx, POS_MIN, POS_MAX);
               ny = clamp_range(ny, POS_MIN, POS_MAX);
            end
         end
      end
      res.new_x = nx[CW-1:0];
      res.new_y = ny[CW-1:0];
      return res;
   endfunction

   //--------------------------------------------------------------------------
   // Stimulus
   //--------------------------------------------------------------------------

   // Values wider than a port are truncated to the port width here.
   task automatic queue_pair(longint cx, longint cy, longint rad, bit ca,
                             longint bx, longint by, longint bw, longint bh, bit ba,
                             bit drain);
      shape_pair_type p;
      p.circle_x      = cx[CW-1:0];
      p.circle_y      = cy[CW-1:0];
      p.circle_radius = rad[CW-2:0];
      p.circle_active = ca;
      p.box_x         = bx[CW-1:0];
      p.box_y         = by[CW-1:0];
      p.box_width     = bw[CW-2:0];
      p.box_height    = bh[CW-2:0];
      p.box_active    = ba;
      p.drain_first   = drain;
      pair_q.insert(pair_q.size(), p);
   endtask

   initial begin
      longint rad, bw, bh, bx, by, mx, my;
      int     kind;
      bit     ca, ba;

      // Directed pairs; the reference box spans (0,0)..(1000,1000), radius 256.
      queue_pair(844, 244, 256, 0, 0, 0, 1000, 1000, 1, 0);   // circle inactive
      queue_pair(844, 244, 256, 1, 0, 0, 1000, 1000, 0, 0);   // box inactive
      queue_pair(844, 244, 256, 0, 0, 0, 1000, 1000, 0, 0);   // both inactive
      queue_pair(844, 244, 256, 1, 0, 0, 1000, 1000, 1, 0);   // push right
      queue_pair(-356, 244, 256, 1, 0, 0, 1000, 1000, 1, 0);  // push left
      queue_pair(244, -356, 256, 1, 0, 0, 1000, 1000, 1, 0);  // push up
      queue_pair(244, 844, 256, 1, 0, 0, 1000, 1000, 1, 0);   // push down
      queue_pair(844, 844, 256, 1, 0, 0, 1000, 1000, 1, 0);   // right/down tie
      queue_pair(-356, -356, 256, 1, 0, 0, 1000, 1000, 1, 0); // left/up tie
      queue_pair(944, 944, 256, 1, 0, 0, 1000, 1000, 1, 0);   // corner near miss
      queue_pair(1000, 244, 256, 1, 0, 0, 1000, 1000, 1, 0);  // offset equals radius
      queue_pair(999, 244, 256, 1, 0, 0, 1000, 1000, 1, 0);   // distance radius - 1
      queue_pair(244, 244, 256, 1, 0, 0, 1000, 1000, 1, 0);   // centre inside box
      queue_pair(500, 500, 0, 1, 0, 0, 1000, 1000, 1, 0);     // centre inside, radius 0
      // Saturation on each side; the first waits for an empty pipeline.
      queue_pair(8388000, 0, 1000, 1, 8387000, 0, SIZE_MAX, 3000, 1, 1);
      queue_pair(POS_MIN, 0, 1000, 1, -8387500, 0, 1000, 3000, 1, 0);
      queue_pair(0, POS_MIN, 1000, 1, 0, -8387500, 3000, 1000, 1, 0);
      queue_pair(0, 8388000, 1000, 1, 0, 8387000, 3000, 1500, 1, 0);
      // Field extremes.
      queue_pair(POS_MIN, POS_MIN, SIZE_MAX, 1, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX, 1, 0);
      queue_pair(POS_MIN, POS_MIN, SIZE_MAX, 1, 0, 0, 0, 0, 1, 0);
      queue_pair(POS_MAX, POS_MAX, SIZE_MAX, 1, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX, 1, 0);
      queue_pair(0, 0, 0, 1, 0, 0, 0, 0, 1, 0);
      queue_pair(0, 0, 100, 1, 150, 100, 0, 0, 1, 0);          // point-sized box

      // Random pairs: mostly placed near each other so hits are common.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = $urandom_range(0, 99);
         ca   = ($urandom_range(0, 19) != 0);
         ba   = ($urandom_range(0, 19) != 0);
         if (kind < 8) begin
            // Noise: every bit of every field free.
            queue_pair($urandom, $urandom, $urandom, $urandom_range(0, 1),
                       $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                       (n % 400) == 199);
         end else begin
            rad = (kind < 16) ? longint'($urandom_range(0, SIZE_MAX))
                              : longint'($urandom_range(0, 4096));
            bw  = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 4 * rad + 16));
            bh  = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 4 * rad + 16));
            if (bw > SIZE_MAX) bw = SIZE_MAX;
            if (bh > SIZE_MAX) bh = SIZE_MAX;
            bx  = longint'($signed(CW'($urandom)));
            by  = longint'($signed(CW'($urandom)));
            // Some boxes hug the edges of the coordinate range to reach saturation.
            if (kind < 22) begin
               if ($urandom_range(0, 1))
                  bx = $urandom_range(0, 1) ? POS_MAX - $urandom_range(0, 4 * rad + 16)
                                            : POS_MIN + $urandom_range(0, 4 * rad + 16);
               else
                  by = $urandom_range(0, 1) ? POS_MAX - $urandom_range(0, 4 * rad + 16)
                                            : POS_MIN + $urandom_range(0, 4 * rad + 16);
            end
            // Centre somewhere over the box, jittered by up to two radii plus two.
            mx = bx + longint'($urandom_range(0, bw))
                    + longint'($urandom_range(0, 4 * rad + 4)) - (2 * rad + 2);
            my = by + longint'($urandom_range(0, bh))
                    + longint'($urandom_range(0, 4 * rad + 4)) - (2 * rad + 2);
            queue_pair(mx - rad, my - rad, rad, ca, bx, by, bw, bh, ba, (n % 400) == 199);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last transaction to go out and its result to come back.
      while (pair_q.size() != 0 || push_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d transactions and %0d results, %0d of them misses.",
               sent_cnt, rsp_cnt, miss_cnt);
      $display("Hits by push direction: right %0d, left %0d, up %0d, down %0d.",
               dir_hits[cbc_pkg::PUSH_RIGHT], dir_hits[cbc_pkg::PUSH_LEFT],
               dir_hits[cbc_pkg::PUSH_UP], dir_hits[cbc_pkg::PUSH_DOWN]);
      if (err_cnt == 0) begin
         $display("[circle_box_collide_resolve_unit] OK");
      end else begin
         $display("%0d mismatches", err_cnt);
         $display("[circle_box_collide_resolve_unit] ERROR");
      end
      $finish;
   end

   //--------------------------------------------------------------------------
   // Driver: the head of pair_q is what start presents; pop it once accepted.
   //--------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && busy === 1'b0) begin
            push_q.insert(push_q.size(), resolve_collision(pair_q[0]));
            void'(pair_q.pop_front());
            sent_cnt++;
         end
         if (start && busy !== 1'b0) begin
            // Hold the current transaction until the unit takes it.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pair_q.size() != 0 &&
                      !(pair_q[0].drain_first && push_q.size() != 0)) begin
            start             <= 1'b1;
            req_circle_x      <= pair_q[0].circle_x;
            req_circle_y      <= pair_q[0].circle_y;
            req_circle_radius <= pair_q[0].circle_radius;
            req_circle_active <= pair_q[0].circle_active;
            req_box_x         <= pair_q[0].box_x;
            req_box_y         <= pair_q[0].box_y;
            req_box_width     <= pair_q[0].box_width;
            req_box_height    <= pair_q[0].box_height;
            req_box_active    <= pair_q[0].box_active;
            // End of a burst: pick the next gap (often none) and burst length.
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   //--------------------------------------------------------------------------
   // Monitor: every strobed result is matched against the oldest prediction.
   //--------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         rsp_cnt++;
         if (push_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
               $display("result %0d: unexpected strobe, hit %b dir %0d x %0d y %0d",
                        rsp_cnt, rsp_hit, rsp_push_direction, rsp_new_x, rsp_new_y);
         end else begin
            push_exp = push_q.pop_front();
            if (rsp_hit !== push_exp.hit || rsp_push_direction !== push_exp.dir ||
                rsp_new_x !== push_exp.new_x || rsp_new_y !== push_exp.new_y) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("result %0d: expected hit %b dir %0d x %0d y %0d, got hit %b dir %0d x %0d y %0d",
                           rsp_cnt, push_exp.hit, push_exp.dir, push_exp.new_x,
                           push_exp.new_y, rsp_hit, rsp_push_direction, rsp_new_x,
                           rsp_new_y);
            end
            if (push_exp.hit)
               dir_hits[push_exp.dir]++;
            else
               miss_cnt++;
         end
      end
   end

   // Watchdog: end the run if nothing moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("no progress for %0d cycles", STALL_LIMIT);
         $display("[circle_box_collide_resolve_unit] ERROR");
         $finish;
      end
   end

endmodule

FILE: sim.f
src/cbc_pkg.sv
src/cbc_sqrt_pipe.sv
src/circle_box_collide_resolve_unit.sv
dv/tb_circle_box_collide_resolve_unit.sv
